// File: rtl/core/quaternion_angle_distance_defines.svh
// Assertion macros for the quaternion angle distance block.
// Used by the port checker; no other dependencies.
`ifndef QUATERNION_ANGLE_DISTANCE_DEFINES_SVH
`define QUATERNION_ANGLE_DISTANCE_DEFINES_SVH

// clocked assertion, quiet while reset is held
`define QAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define QAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/qad_pkg.sv
// Shared types, widths and constants for the quaternion angle distance block.
// No dependencies.
`default_nettype none
package qad_pkg;

  localparam int COMP_BITS = 16;
  localparam int RED_SHIFT = (COMP_BITS > 16) ? COMP_BITS - 16 : 0;
  localparam int CW = 16;            // component after scaling
  localparam int PRW = 2 * CW;       // one product
  localparam int PW = PRW + 2;       // sum of four products
  localparam int MW = PW - 3;        // |sum| >> 2
  localparam int SW = 2 * MW;        // square, sum of three squares
  localparam int SQRT_STEPS = SW / 2;
  localparam int XW = MW + 5;        // cordic x/y with growth
  localparam int ZW = 20;            // cordic angle, radians * 2^16
  localparam int CORDIC_STEPS = 17;
  localparam int AW = 21;

  localparam logic signed [AW-1:0] ANG_PI = AW'(205887);
  localparam logic signed [AW-1:0] ANG_HALF_PI = AW'(102944);
  localparam logic signed [AW-1:0] ANG_TWO_PI = AW'(411774);
  localparam logic signed [AW-1:0] ANGLE_MAX = AW'(38604);

  typedef struct packed {
    logic signed [COMP_BITS-1:0] ref_qw;
    logic signed [COMP_BITS-1:0] ref_qx;
    logic signed [COMP_BITS-1:0] ref_qy;
    logic signed [COMP_BITS-1:0] ref_qz;
    logic signed [COMP_BITS-1:0] est_qw;
    logic signed [COMP_BITS-1:0] est_qx;
    logic signed [COMP_BITS-1:0] est_qy;
    logic signed [COMP_BITS-1:0] est_qz;
  } in_t;

  typedef struct packed {
    logic [15:0] angle;
    logic        degenerate;
  } out_t;

  // flags carried along the chain
  typedef struct packed {
    logic degen;
    logic wneg;
    logic xzero;
    logic allzero;
  } side_t;

  function automatic logic signed [CW-1:0] load_comp(input logic signed [COMP_BITS-1:0] v);
    logic signed [COMP_BITS:0] ext;
    logic [COMP_BITS:0] mag;
    logic [COMP_BITS:0] shr;
    logic [COMP_BITS:0] res;
    ext = {v[COMP_BITS-1], v};
    mag = ext[COMP_BITS] ? (COMP_BITS+1)'(-ext) : (COMP_BITS+1)'(ext);
    shr = mag >> RED_SHIFT;
    res = ext[COMP_BITS] ? (COMP_BITS+1)'(-shr) : shr;
    return CW'(signed'(res));
  endfunction

  function automatic logic signed [ZW-1:0] atan_val(input int i);
    case (i)
      0: return ZW'(51472);
      1: return ZW'(30386);
      2: return ZW'(16055);
      3: return ZW'(8150);
      4: return ZW'(4091);
      5: return ZW'(2047);
      6: return ZW'(1024);
      7: return ZW'(512);
      8: return ZW'(256);
      9: return ZW'(128);
      10: return ZW'(64);
      11: return ZW'(32);
      12: return ZW'(16);
      13: return ZW'(8);
      14: return ZW'(4);
      15: return ZW'(2);
      16: return ZW'(1);
      default: return '0;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/qad_front.sv
// Front pipeline: scaling, products, dot and vector part, squares.
// Depends on qad_pkg.
`default_nettype none
module qad_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic          in_v,
  input  wire qad_pkg::in_t  in_d,
  output logic               out_v,
  output logic [qad_pkg::SW-1:0] out_sum,
  output logic [qad_pkg::MW-1:0] out_x,
  output qad_pkg::side_t     out_side
);
  import qad_pkg::*;

  logic [5:0] v_r, v_nxt;
  logic signed [CW-1:0] c_r [8];
  logic degen_r, degen1_r, degen2_r, degen3_r, degen4_r, degen5_r;
  logic signed [PRW-1:0] p_r [16];
  logic signed [PW-1:0] w_r, vx_r, vy_r, vz_r;
  logic [MW-1:0] x_r, sx_r, sy_r, sz_r, x4_r, x5_r;
  logic wneg_r, wneg4_r, wneg5_r;
  logic [SW-1:0] qx_r, qy_r, qz_r, sum_r;
  logic ref_zero, est_zero;
  logic [PW-1:0] mw, mx, my, mz;

  assign ref_zero = (in_d.ref_qw == '0) && (in_d.ref_qx == '0) &&
                    (in_d.ref_qy == '0) && (in_d.ref_qz == '0);
  assign est_zero = (in_d.est_qw == '0) && (in_d.est_qx == '0) &&
                    (in_d.est_qy == '0) && (in_d.est_qz == '0);

  // one valid bit per front stage
  assign v_nxt = {v_r[4:0], in_v};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= v_nxt;
    end
  end

  // p order: aw*bw ax*bx ay*by az*bz | aw*bx bw*ax ay*bz az*by |
  //          aw*by bw*ay az*bx ax*bz | aw*bz bw*az ax*by ay*bx
  assign mw = w_r[PW-1] ? PW'(-w_r) : PW'(w_r);
  assign mx = vx_r[PW-1] ? PW'(-vx_r) : PW'(vx_r);
  assign my = vy_r[PW-1] ? PW'(-vy_r) : PW'(vy_r);
  assign mz = vz_r[PW-1] ? PW'(-vz_r) : PW'(vz_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r[0] <= load_comp(in_d.ref_qw);
      c_r[1] <= load_comp(in_d.ref_qx);
      c_r[2] <= load_comp(in_d.ref_qy);
      c_r[3] <= load_comp(in_d.ref_qz);
      c_r[4] <= load_comp(in_d.est_qw);
      c_r[5] <= load_comp(in_d.est_qx);
      c_r[6] <= load_comp(in_d.est_qy);
      c_r[7] <= load_comp(in_d.est_qz);
      degen_r <= ref_zero || est_zero;

      p_r[0] <= c_r[0] * c_r[4];
      p_r[1] <= c_r[1] * c_r[5];
      p_r[2] <= c_r[2] * c_r[6];
      p_r[3] <= c_r[3] * c_r[7];
      p_r[4] <= c_r[0] * c_r[5];
      p_r[5] <= c_r[4] * c_r[1];
      p_r[6] <= c_r[2] * c_r[7];
      p_r[7] <= c_r[3] * c_r[6];
      p_r[8] <= c_r[0] * c_r[6];
      p_r[9] <= c_r[4] * c_r[2];
      p_r[10] <= c_r[3] * c_r[5];
      p_r[11] <= c_r[1] * c_r[7];
      p_r[12] <= c_r[0] * c_r[7];
      p_r[13] <= c_r[4] * c_r[3];
      p_r[14] <= c_r[1] * c_r[6];
      p_r[15] <= c_r[2] * c_r[5];
      degen1_r <= degen_r;

      w_r <= PW'(p_r[0]) + PW'(p_r[1]) + PW'(p_r[2]) + PW'(p_r[3]);
      vx_r <= PW'(p_r[4]) - PW'(p_r[5]) - (PW'(p_r[6]) - PW'(p_r[7]));
      vy_r <= PW'(p_r[8]) - PW'(p_r[9]) - (PW'(p_r[10]) - PW'(p_r[11]));
      vz_r <= PW'(p_r[12]) - PW'(p_r[13]) - (PW'(p_r[14]) - PW'(p_r[15]));
      degen2_r <= degen1_r;

      x_r <= MW'(mw >> 2);
      sx_r <= MW'(mx >> 2);
      sy_r <= MW'(my >> 2);
      sz_r <= MW'(mz >> 2);
      wneg_r <= w_r[PW-1];
      degen3_r <= degen2_r;

      qx_r <= SW'(sx_r) * SW'(sx_r);
      qy_r <= SW'(sy_r) * SW'(sy_r);
      qz_r <= SW'(sz_r) * SW'(sz_r);
      x4_r <= x_r;
      wneg4_r <= wneg_r;
      degen4_r <= degen3_r;

      sum_r <= qx_r + qy_r + qz_r;
      x5_r <= x4_r;
      wneg5_r <= wneg4_r;
      degen5_r <= degen4_r;
    end
  end

  assign out_v = v_r[5];
  assign out_sum = sum_r;
  assign out_x = x5_r;
  assign out_side = '{degen: degen5_r, wneg: wneg5_r, xzero: (x5_r == '0), allzero: 1'b0};

endmodule
`default_nettype wire

// File: rtl/core/qad_sqrt_cell.sv
// One digit cell of the integer square root chain.
// Depends on qad_pkg.
`default_nettype none
module qad_sqrt_cell #(
  parameter int STEP = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               in_v,
  input  wire logic [qad_pkg::SW-1:0] in_n,
  input  wire logic [qad_pkg::SW-1:0] in_r,
  input  wire logic [qad_pkg::MW-1:0] in_x,
  input  wire qad_pkg::side_t     in_side,
  output logic                    out_v,
  output logic [qad_pkg::SW-1:0]  out_n,
  output logic [qad_pkg::SW-1:0]  out_r,
  output logic [qad_pkg::MW-1:0]  out_x,
  output qad_pkg::side_t          out_side
);
  import qad_pkg::*;

  localparam int K = SQRT_STEPS - 1 - STEP;
  localparam logic [SW:0] BIT = (SW+1)'(1) << (2 * K);

  logic v_r;
  logic [SW-1:0] n_r, r_r, n_nxt, r_nxt;
  logic [MW-1:0] x_r;
  side_t side_r;
  logic [SW:0] trial;

  assign trial = {1'b0, in_r} + BIT;

  always_comb begin
    if ({1'b0, in_n} >= trial) begin
      n_nxt = SW'({1'b0, in_n} - trial);
      r_nxt = SW'((in_r >> 1) + SW'(BIT));
    end else begin
      n_nxt = in_n;
      r_nxt = in_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r <= n_nxt;
      r_r <= r_nxt;
      x_r <= in_x;
      side_r <= in_side;
    end
  end

  assign out_v = v_r;
  assign out_n = n_r;
  assign out_r = r_r;
  assign out_x = x_r;
  assign out_side = side_r;

endmodule
`default_nettype wire

// File: rtl/core/qad_cordic_cell.sv
// One vectoring rotation cell of the atan2 chain.
// Depends on qad_pkg.
`default_nettype none
module qad_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,
  input  wire logic                      in_v,
  input  wire logic signed [qad_pkg::XW-1:0] in_x,
  input  wire logic signed [qad_pkg::XW-1:0] in_y,
  input  wire logic signed [qad_pkg::ZW-1:0] in_z,
  input  wire qad_pkg::side_t            in_side,
  output logic                           out_v,
  output logic signed [qad_pkg::XW-1:0]  out_x,
  output logic signed [qad_pkg::XW-1:0]  out_y,
  output logic signed [qad_pkg::ZW-1:0]  out_z,
  output qad_pkg::side_t                 out_side
);
  import qad_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = atan_val(STEP);

  logic v_r;
  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [ZW-1:0] z_r, z_nxt;
  side_t side_r;

  assign dx = in_y >>> STEP;
  assign dy = in_x >>> STEP;

  always_comb begin
    x_nxt = in_x;
    y_nxt = in_y;
    z_nxt = in_z;
    if (in_y > 0) begin
      x_nxt = in_x + dx;
      y_nxt = in_y - dy;
      z_nxt = in_z + ATAN;
    end else if (in_y < 0) begin
      x_nxt = in_x - dx;
      y_nxt = in_y + dy;
      z_nxt = in_z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      side_r <= in_side;
    end
  end

  assign out_v = v_r;
  assign out_x = x_r;
  assign out_y = y_r;
  assign out_z = z_r;
  assign out_side = side_r;

endmodule
`default_nettype wire

// File: rtl/core/quaternion_angle_distance.sv
// Top level: front pipeline, square root cell chain, atan2 cell chain, output register.
// Depends on qad_pkg, qad_front, qad_sqrt_cell, qad_cordic_cell.
//
//   channel  ports                       payload
//   input    in_valid / in_stall         in_data  (qad_pkg::in_t)
//   result   out_valid / out_stall       out_data (qad_pkg::out_t)
//
// One pair per cycle while the result is not stalled; the chain is 6 front stages, 31 square root
// cells (one root bit each), 17 atan2 cells, one output register.
// rst_n clears only the valid bits of the chain.
// A stalled result freezes the whole chain; in_stall is high exactly then.
`default_nettype none
module quaternion_angle_distance (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire qad_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output qad_pkg::out_t      out_data
);
  import qad_pkg::*;

  logic adv;
  logic out_valid_r;
  out_t out_r, out_nxt;

  logic          sq_v    [SQRT_STEPS+1];
  logic [SW-1:0] sq_n    [SQRT_STEPS+1];
  logic [SW-1:0] sq_r    [SQRT_STEPS+1];
  logic [MW-1:0] sq_x    [SQRT_STEPS+1];
  side_t         sq_side [SQRT_STEPS+1];

  logic                 cd_v    [CORDIC_STEPS+1];
  logic signed [XW-1:0] cd_x    [CORDIC_STEPS+1];
  logic signed [XW-1:0] cd_y    [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cd_z    [CORDIC_STEPS+1];
  side_t                cd_side [CORDIC_STEPS+1];

  assign adv = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  qad_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (in_valid),
    .in_d     (in_data),
    .out_v    (sq_v[0]),
    .out_sum  (sq_n[0]),
    .out_x    (sq_x[0]),
    .out_side (sq_side[0])
  );
  assign sq_r[0] = '0;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    qad_sqrt_cell #(.STEP(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_v     (sq_v[i]),
      .in_n     (sq_n[i]),
      .in_r     (sq_r[i]),
      .in_x     (sq_x[i]),
      .in_side  (sq_side[i]),
      .out_v    (sq_v[i+1]),
      .out_n    (sq_n[i+1]),
      .out_r    (sq_r[i+1]),
      .out_x    (sq_x[i+1]),
      .out_side (sq_side[i+1])
    );
  end

  assign cd_v[0] = sq_v[SQRT_STEPS];
  assign cd_x[0] = XW'(signed'({1'b0, sq_x[SQRT_STEPS]}));
  assign cd_y[0] = XW'(signed'({1'b0, sq_r[SQRT_STEPS]}));
  assign cd_z[0] = '0;
  always_comb begin
    cd_side[0] = sq_side[SQRT_STEPS];
    cd_side[0].allzero = sq_side[SQRT_STEPS].xzero && (sq_r[SQRT_STEPS] == '0);
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    qad_cordic_cell #(.STEP(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_v     (cd_v[i]),
      .in_x     (cd_x[i]),
      .in_y     (cd_y[i]),
      .in_z     (cd_z[i]),
      .in_side  (cd_side[i]),
      .out_v    (cd_v[i+1]),
      .out_x    (cd_x[i+1]),
      .out_y    (cd_y[i+1]),
      .out_z    (cd_z[i+1]),
      .out_side (cd_side[i+1])
    );
  end

  // final angle: clamp, quadrant fold, double, wrap, round to Q3.13
  logic signed [AW-1:0] z_cl, h, a1, a, q;
  side_t fs;

  always_comb begin
    fs = cd_side[CORDIC_STEPS];
    z_cl = AW'(cd_z[CORDIC_STEPS]);
    if (z_cl < 0) begin
      z_cl = '0;
    end else if (z_cl > ANG_HALF_PI) begin
      z_cl = ANG_HALF_PI;
    end
    if (fs.allzero) begin
      h = '0;
    end else if (fs.wneg && !fs.xzero) begin
      h = ANG_PI - z_cl;
    end else begin
      h = z_cl;
    end
    a1 = h <<< 1;
    a = (a1 > ANG_HALF_PI) ? ANG_TWO_PI - a1 : a1;
    if (a < 0) begin
      a = '0;
    end
    q = (a + AW'(4)) >>> 3;
    if (q > ANGLE_MAX) begin
      q = ANGLE_MAX;
    end
    if (fs.degen) begin
      out_nxt.angle = '0;
      out_nxt.degenerate = 1'b1;
    end else begin
      out_nxt.angle = q[15:0];
      out_nxt.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cd_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule
`default_nettype wire

// File: rtl/core/qad_checker.sv
// Port-level checker for quaternion_angle_distance, bound to the top level.
// Depends on qad_pkg and quaternion_angle_distance_defines.svh.
`default_nettype none
`include "quaternion_angle_distance_defines.svh"
module qad_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire qad_pkg::out_t out_data
);
  import qad_pkg::*;

  `QAD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result dropped or changed while stalled")
  `QAD_ASSERT(a_degen_zero, out_valid && out_data.degenerate |-> out_data.angle == 16'd0, "degenerate result with nonzero angle")
  `QAD_ASSERT(a_angle_max, out_valid |-> out_data.angle <= 16'd38604, "angle above three half pi")
  `QAD_ASSERT(a_in_stall, in_stall == (out_valid && out_stall), "input stall not tied to a held result")
  `QAD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind quaternion_angle_distance qad_checker u_qad_checker (.*);
`default_nettype wire
